// ===== sv/swl_pkg.sv =====
// ----------------------------------------------------------------------------
// swl_pkg
// Shared types, constants and the segment decoder for the stopwatch core.
// ----------------------------------------------------------------------------
package swl_pkg;

  localparam int SEG_W       = 7;
  localparam int MIN_PAIR_W  = 15;
  localparam int SEC_QUAD_W  = 31;

  typedef logic [3:0] dec_digit_t;
  typedef logic [2:0] hex_tens_t;

  localparam dec_digit_t DEC_MAX  = 4'd9;
  localparam hex_tens_t  TENS_MAX = 3'd5;

  typedef logic [SEG_W-1:0] seg_t;

  // Time held as MM:SS:HH digits; always below one hour.
  typedef struct packed {
    hex_tens_t  min_tens;
    dec_digit_t min_ones;
    hex_tens_t  sec_tens;
    dec_digit_t sec_ones;
    dec_digit_t hun_tens;
    dec_digit_t hun_ones;
  } time_t;

  localparam time_t TIME_ZERO = '0;

  // Segment a in bit 0, segment g in bit 6; codes of ten and above are blank.
  function automatic seg_t seg_of(input dec_digit_t digit);
    seg_t pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== sv/swl_channels.sv =====
// ----------------------------------------------------------------------------
// swl_channels
// Valid/ready channels for stopwatch key samples and display patterns.
// ----------------------------------------------------------------------------
interface swl_in_if;
  logic valid;
  logic ready;
  logic start_key;
  logic stop_key;
  logic lap_key;
  logic clear_key;
  logic show_lap;
  logic tick;

  modport source (output valid, output start_key, output stop_key, output lap_key,
                  output clear_key, output show_lap, output tick, input ready);
  modport sink   (input valid, input start_key, input stop_key, input lap_key,
                  input clear_key, input show_lap, input tick, output ready);
endinterface

interface swl_out_if;
  logic                               valid;
  logic                               ready;
  logic [swl_pkg::MIN_PAIR_W-1:0]     minutes_pair;
  logic [swl_pkg::SEC_QUAD_W-1:0]     seconds_hundredths_quad;

  modport source (output valid, output minutes_pair, output seconds_hundredths_quad,
                  input ready);
  modport sink   (input valid, input minutes_pair, input seconds_hundredths_quad,
                  output ready);
endinterface

// ===== sv/stopwatch_lap_seven_segment_core.sv =====
// ----------------------------------------------------------------------------
// stopwatch_lap_seven_segment_core
// Hundredths-of-a-second stopwatch with lap store and MM:SS:HH segment output.
// ----------------------------------------------------------------------------
// Each input item is one sample of the start, stop, lap and clear keys, the
// display switch and the hundredth-second tick; it yields one item of segment
// patterns for the selected time in the cycle after it is taken. The block takes
// one item per clock as long as the output register is free or being drained,
// and the time is kept as digit counters, so the only path per item is the
// key logic, one digit carry chain and the segment decode into the output
// register. The count wraps to zero at one hour; clear keeps the run state.
module stopwatch_lap_seven_segment_core
  import swl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  swl_in_if.sink     in_ch,
  swl_out_if.source  out_ch
);

  time_t elapsed_r, elapsed_nxt;
  time_t lap_r, lap_nxt;
  logic  run_r, run_nxt;
  time_t shown;

  logic                  out_valid_r;
  logic [MIN_PAIR_W-1:0] min_pair_r, min_pair_nxt;
  logic [SEC_QUAD_W-1:0] sec_quad_r, sec_quad_nxt;

  logic in_take;

  function automatic time_t time_inc(input time_t t);
    time_t r;
    r = t;
    if (t.hun_ones != DEC_MAX) begin
      r.hun_ones = t.hun_ones + 4'd1;
    end else begin
      r.hun_ones = '0;
      if (t.hun_tens != DEC_MAX) begin
        r.hun_tens = t.hun_tens + 4'd1;
      end else begin
        r.hun_tens = '0;
        if (t.sec_ones != DEC_MAX) begin
          r.sec_ones = t.sec_ones + 4'd1;
        end else begin
          r.sec_ones = '0;
          if (t.sec_tens != TENS_MAX) begin
            r.sec_tens = t.sec_tens + 3'd1;
          end else begin
            r.sec_tens = '0;
            if (t.min_ones != DEC_MAX) begin
              r.min_ones = t.min_ones + 4'd1;
            end else begin
              r.min_ones = '0;
              if (t.min_tens != TENS_MAX) begin
                r.min_tens = t.min_tens + 3'd1;
              end else begin
                r.min_tens = '0;
              end
            end
          end
        end
      end
    end
    return r;
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    run_nxt     = (run_r || in_ch.start_key) && !in_ch.stop_key;
    lap_nxt     = in_ch.lap_key ? elapsed_r : lap_r;
    elapsed_nxt = elapsed_r;
    if (in_ch.clear_key) begin
      lap_nxt     = TIME_ZERO;
      elapsed_nxt = TIME_ZERO;
    end
    if (run_nxt && in_ch.tick) begin
      elapsed_nxt = time_inc(elapsed_nxt);
    end
    shown = in_ch.show_lap ? lap_nxt : elapsed_nxt;

    min_pair_nxt = {seg_of({1'b0, shown.min_tens}), 1'b0, seg_of(shown.min_ones)};
    sec_quad_nxt = {seg_of({1'b0, shown.sec_tens}), 1'b0, seg_of(shown.sec_ones), 1'b0,
                    seg_of(shown.hun_tens), 1'b0, seg_of(shown.hun_ones)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= TIME_ZERO;
      lap_r       <= TIME_ZERO;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        elapsed_r   <= elapsed_nxt;
        lap_r       <= lap_nxt;
        run_r       <= run_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      min_pair_r <= min_pair_nxt;
      sec_quad_r <= sec_quad_nxt;
    end
  end

  assign out_ch.valid                   = out_valid_r;
  assign out_ch.minutes_pair            = min_pair_r;
  assign out_ch.seconds_hundredths_quad = sec_quad_r;

endmodule
